FILE: rtl/core/tsro_pkg.sv
`timescale 1ns / 1ps

package tsro_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned TYPE_W  = 3;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_DPOP  = 3'd2,
    OP_PEEK  = 3'd3,
    OP_FLUSH = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIDIR   = 2'd0,
    CFG_INVALID = 2'd1
  } cfg_idx_e;

  localparam logic [TYPE_W-1:0] BIDIR_RESET   = 3'd3;
  localparam logic [TYPE_W-1:0] INVALID_RESET = 3'd0;

  typedef struct packed {
    logic signed [STAMP_W-1:0] stamp;
    logic [TYPE_W-1:0]         typ;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the transaction and read head / second entries
    logic commit;   // apply the operation and load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rsp_free; // result register can take a new result this cycle
  } dp_status_t;

endpackage

FILE: rtl/core/tsro_if.sv
`timescale 1ns / 1ps

interface tsro_in_if;
  logic                                valid;
  logic                                ready;
  logic [tsro_pkg::OP_W-1:0]           operation;
  logic signed [tsro_pkg::STAMP_W-1:0] stamp_in;
  logic [tsro_pkg::TYPE_W-1:0]         type_in;

  modport source (output valid, operation, stamp_in, type_in, input ready);
  modport sink   (input valid, operation, stamp_in, type_in, output ready);
endinterface

interface tsro_out_if #(
  parameter int unsigned FILL_W = 7
);
  logic                                valid;
  logic                                ready;
  logic signed [tsro_pkg::STAMP_W-1:0] stamp_out;
  logic [tsro_pkg::TYPE_W-1:0]         type_out;
  logic                                entry_valid;
  logic                                push_accepted;
  logic [FILL_W-1:0]                   fill_count;

  modport source (output valid, stamp_out, type_out, entry_valid, push_accepted, fill_count,
                  input ready);
  modport sink   (input valid, stamp_out, type_out, entry_valid, push_accepted, fill_count,
                  output ready);
endinterface

interface tsro_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [tsro_pkg::CFG_IDX_W-1:0]       index;
  logic [tsro_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tsro_ctrl.sv
`timescale 1ns / 1ps

module tsro_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  tsro_pkg::dp_status_t   status_i,
  output tsro_pkg::ctrl_cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register is free
        if (status_i.rsp_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/tsro_dpath.sv
`timescale 1ns / 1ps

module tsro_dpath #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tsro_pkg::ctrl_cmd_t                 cmd_i,
  output tsro_pkg::dp_status_t                status_o,
  input  logic [tsro_pkg::OP_W-1:0]           operation_i,
  input  logic signed [tsro_pkg::STAMP_W-1:0] stamp_i,
  input  logic [tsro_pkg::TYPE_W-1:0]         type_i,
  tsro_cfg_if.sink                            cfg_i,
  tsro_out_if.source                          rsp_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  // ring store
  tsro_pkg::entry_t mem [QUEUE_DEPTH];

  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [tsro_pkg::TYPE_W-1:0] bidir_q, invalid_q;

  // captured transaction and entries read at capture
  logic [tsro_pkg::OP_W-1:0]  op_q;
  tsro_pkg::entry_t           item_q;
  tsro_pkg::entry_t           head_q, second_q;

  logic [PTR_W-1:0] second_ptr;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  tsro_pkg::entry_t wr_data;
  tsro_pkg::entry_t res_entry;
  logic             res_valid, res_accepted;

  // result register
  logic                                rsp_valid_q;
  logic signed [tsro_pkg::STAMP_W-1:0] rsp_stamp_q;
  logic [tsro_pkg::TYPE_W-1:0]         rsp_type_q;
  logic                                rsp_entry_q, rsp_acc_q;
  logic [CNT_W-1:0]                    rsp_fill_q;

  assign second_ptr = ring_next(rd_ptr_q);

  always_comb begin
    rd_ptr_d      = rd_ptr_q;
    wr_ptr_d      = wr_ptr_q;
    count_d       = count_q;
    wr_en         = 1'b0;
    wr_addr       = wr_ptr_q;
    wr_data       = item_q;
    res_entry.stamp = '0;
    res_entry.typ   = invalid_q;
    res_valid     = 1'b0;
    res_accepted  = 1'b0;
    unique case (op_q)
      tsro_pkg::OP_PUSH: begin
        if (count_q != CNT_FULL) begin
          wr_en        = 1'b1;
          wr_ptr_d     = ring_next(wr_ptr_q);
          count_d      = count_q + CNT_W'(1);
          res_accepted = 1'b1;
        end
      end
      tsro_pkg::OP_POP, tsro_pkg::OP_PEEK: begin
        if (count_q != '0) begin
          res_entry = head_q;
          res_valid = 1'b1;
          if (op_q == tsro_pkg::OP_POP) begin
            rd_ptr_d = second_ptr;
            count_d  = count_q - CNT_W'(1);
          end
        end
      end
      tsro_pkg::OP_DPOP: begin
        if (count_q != '0) begin
          if (count_q >= CNT_W'(2) && head_q.typ != bidir_q && second_q.typ == bidir_q) begin
            // take the bidirectional entry, move the head into its slot
            res_entry = second_q;
            wr_en     = 1'b1;
            wr_addr   = second_ptr;
            wr_data   = head_q;
          end else begin
            res_entry = head_q;
          end
          res_valid = 1'b1;
          rd_ptr_d  = second_ptr;
          count_d   = count_q - CNT_W'(1);
        end
      end
      tsro_pkg::OP_FLUSH: begin
        rd_ptr_d = '0;
        wr_ptr_d = '0;
        count_d  = '0;
      end
      default: ;
    endcase
  end

  assign status_o.rsp_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q         <= operation_i;
      item_q.stamp <= stamp_i;
      item_q.typ   <= type_i;
      head_q       <= mem[rd_ptr_q];
      second_q     <= mem[second_ptr];
    end
    if (cmd_i.commit && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.commit) begin
      rsp_stamp_q <= res_entry.stamp;
      rsp_type_q  <= res_entry.typ;
      rsp_entry_q <= res_valid;
      rsp_acc_q   <= res_accepted;
      rsp_fill_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      bidir_q     <= tsro_pkg::BIDIR_RESET;
      invalid_q   <= tsro_pkg::INVALID_RESET;
    end else begin
      if (cmd_i.commit) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        count_q  <= count_d;
      end
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        if (cfg_i.index == tsro_pkg::CFG_BIDIR) begin
          bidir_q <= cfg_i.data;
        end else if (cfg_i.index == tsro_pkg::CFG_INVALID) begin
          invalid_q <= cfg_i.data;
        end
      end
    end
  end

  assign cfg_i.ready         = 1'b1;
  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.stamp_out     = rsp_stamp_q;
  assign rsp_o.type_out      = rsp_type_q;
  assign rsp_o.entry_valid   = rsp_entry_q;
  assign rsp_o.push_accepted = rsp_acc_q;
  assign rsp_o.fill_count    = rsp_fill_q;

endmodule

FILE: rtl/core/timestamp_reorder_fifo_unit.sv
`timescale 1ns / 1ps
// Timestamp reorder queue: a ring of presentation timestamps, each tagged
// with a picture coding type.
// Channels:
//   cmd_i  - one transaction per operation: push, pop, display-order pop,
//            peek or flush, with the timestamp and type to push.
//   rsp_o  - exactly one result transaction per command: returned stamp and
//            type, entry-valid and push-accepted flags, fill count after it.
//   cfg_i  - register writes (0 bidirectional type, 1 invalid type); always
//            ready, indexes beyond the list are dropped.
// Timing: a command is captured at acceptance and commits once the result
// register is free; the commit loads the result register, and the next
// command is taken in the cycle after it. This sequence is set by the ring
// memory reads, registered at acceptance (head and second entry) before commit.
// Reset empties the queue (pointers and count to zero), loads register
// defaults and drops any pending result; the ring contents are not cleared.
// When the receiver stalls, the result register holds its transaction; one
// further command is still accepted and waits until the register drains.
module timestamp_reorder_fifo_unit #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsro_in_if.sink    cmd_i,
  tsro_cfg_if.sink   cfg_i,
  tsro_out_if.source rsp_o
);

  tsro_pkg::ctrl_cmd_t  ctrl_cmd;
  tsro_pkg::dp_status_t dp_status;

  // sequencer: accept, then commit once the result register is free
  tsro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // ring store, pointers, registers and result register
  tsro_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .operation_i (cmd_i.operation),
    .stamp_i     (cmd_i.stamp_in),
    .type_i      (cmd_i.type_in),
    .cfg_i       (cfg_i),
    .rsp_o       (rsp_o)
  );

  // one command in flight: no acceptance right after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> !cmd_i.ready)
    else $error("command accepted while previous one in flight");

  // a commit always leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.commit |=> rsp_o.valid)
    else $error("commit did not load result register");

  // fill count never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.fill_count <= QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  // a result never both returns an entry and stores one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.entry_valid && rsp_o.push_accepted))
    else $error("entry returned on a push");

endmodule

FILE: tb/sv/timestamp_reorder_fifo_unit_test.sv
`timescale 1ns / 1ps

module timestamp_reorder_fifo_unit_test;
  import tsro_pkg::*;

  localparam int unsigned QUEUE_DEPTH     = 64;
  localparam int unsigned FILL_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS    = 1425;
  localparam int unsigned PHASE_ITEMS     = 300;
  localparam int unsigned DRAIN_CYCLES    = 10;
  localparam int unsigned MAX_REPORTS     = 20;

  // Opcodes and register indexes the block has no use for; it must leave
  // the queue alone and answer a spare opcode as for an empty pop.
  localparam logic [OP_W-1:0]      OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0]      OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0]      OP_SPARE_HI  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic signed [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};
  localparam logic signed [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};

  typedef struct {
    logic signed [STAMP_W-1:0] stamp;
    logic [TYPE_W-1:0]         typ;
    logic                      entry_valid;
    logic                      push_accepted;
    logic [FILL_W-1:0]         fill;
  } queue_result_t;

  // Shadow copy of the ring: applies each accepted command in order and
  // keeps the results that the block owes, oldest first.
  class reorder_scoreboard;
    logic signed [STAMP_W-1:0] stamp_ring [QUEUE_DEPTH];
    logic [TYPE_W-1:0]         type_ring  [QUEUE_DEPTH];
    int unsigned               head_ptr;
    int unsigned               tail_ptr;
    int unsigned               held;
    logic [TYPE_W-1:0]         bidir_code   = BIDIR_RESET;
    logic [TYPE_W-1:0]         invalid_code = INVALID_RESET;
    queue_result_t             awaited[$];
    int unsigned               errors;
    int unsigned               checked;
    int unsigned               swaps;
    int unsigned               refused;

    function int unsigned advance(int unsigned p);
      return (p + 1 == QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_BIDIR:   bidir_code = value;
        CFG_INVALID: invalid_code = value;
        default: ;
      endcase
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic signed [STAMP_W-1:0] stamp,
                               logic [TYPE_W-1:0] typ);
      queue_result_t r;
      int unsigned   second;
      r.stamp         = '0;
      r.typ           = invalid_code;
      r.entry_valid   = 1'b0;
      r.push_accepted = 1'b0;
      second          = advance(head_ptr);
      case (op)
        OP_PUSH: if (held < QUEUE_DEPTH) begin
          stamp_ring[tail_ptr] = stamp;
          type_ring[tail_ptr]  = typ;
          tail_ptr             = advance(tail_ptr);
          held++;
          r.push_accepted = 1'b1;
        end else begin
          refused++;
        end
        OP_POP, OP_PEEK: if (held != 0) begin
          r.stamp       = stamp_ring[head_ptr];
          r.typ         = type_ring[head_ptr];
          r.entry_valid = 1'b1;
          if (op == OP_POP) begin
            head_ptr = second;
            held--;
          end
        end
        OP_DPOP: if (held != 0) begin
          if (held >= 2 && type_ring[head_ptr] != bidir_code &&
              type_ring[second] == bidir_code) begin
            // Take the bidirectional second entry; the head slides into its slot.
            r.stamp            = stamp_ring[second];
            r.typ              = type_ring[second];
            stamp_ring[second] = stamp_ring[head_ptr];
            type_ring[second]  = type_ring[head_ptr];
            swaps++;
          end else begin
            r.stamp = stamp_ring[head_ptr];
            r.typ   = type_ring[head_ptr];
          end
          r.entry_valid = 1'b1;
          head_ptr      = second;
          held--;
        end
        OP_FLUSH: begin
          head_ptr = 0;
          tail_ptr = 0;
          held     = 0;
        end
        default: ;
      endcase
      r.fill = FILL_W'(held);
      awaited.push_back(r);
    endfunction

    function void compare(string field, logic [STAMP_W-1:0] want, logic [STAMP_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, actual stamp %0h fill %0d",
                 $time, got.stamp, got.fill);
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare("stamp_out", want.stamp, got.stamp);
      compare("type_out", STAMP_W'(want.typ), STAMP_W'(got.typ));
      compare("entry_valid", STAMP_W'(want.entry_valid), STAMP_W'(got.entry_valid));
      compare("push_accepted", STAMP_W'(want.push_accepted), STAMP_W'(got.push_accepted));
      compare("fill_count", STAMP_W'(want.fill), STAMP_W'(got.fill));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        calm         = 1'b0;  // suppress gaps on both sides
  logic        hold_off     = 1'b0;  // long receiver stall in progress
  logic        pressure_req = 1'b0;
  int unsigned sent;
  int unsigned settings;
  int unsigned cycles;

  reorder_scoreboard board = new();

  tsro_in_if                   cmd_if ();
  tsro_cfg_if                  cfg_if ();
  tsro_out_if #(.FILL_W(FILL_W)) rsp_if ();

  timestamp_reorder_fifo_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .cfg_i (cfg_if),
    .rsp_o (rsp_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Gap length: mostly none, often a few cycles, now and then a long stretch.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Stamps: hit both extremes and zero now and then, random otherwise.
  function automatic logic signed [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(9))
      0: return STAMP_MIN;
      1: return STAMP_MAX;
      2: return '0;
      default: return $urandom();
    endcase
  endfunction

  // Favor the bidirectional code so display-order pops actually reorder.
  function automatic logic [TYPE_W-1:0] pick_type();
    if ($urandom_range(9) < 4) return board.bidir_code;
    return TYPE_W'($urandom_range(7));
  endfunction

  // Offer one command after an optional gap; return at the edge that takes it.
  // Keep valid high on return so back-to-back commands need no toggle.
  task automatic issue(logic [OP_W-1:0] op, logic signed [STAMP_W-1:0] stamp,
                       logic [TYPE_W-1:0] typ);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.operation <= op;
    cmd_if.stamp_in  <= stamp;
    cmd_if.type_in   <= typ;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    board.note_command(op, stamp, typ);
    sent++;
  endtask

  // Drop valid and hold until every owed result has been taken.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.set_register(idx, value);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(logic [TYPE_W-1:0] bidir, logic [TYPE_W-1:0] invalid);
    wait_idle();
    load_register(CFG_BIDIR, bidir);
    load_register(CFG_INVALID, invalid);
    settings++;
  endtask

  // One stretch of random traffic, shaped like a decoder front end most of the time.
  task automatic run_episode();
    int unsigned      kind;
    int unsigned      n;
    int unsigned      roll;
    logic [OP_W-1:0]  op;
    kind = $urandom_range(9);
    calm = ($urandom_range(4) == 0);
    if (kind < 2) begin
      // Fill to the brim, then knock on the full queue a few times.
      n = QUEUE_DEPTH - board.held + $urandom_range(3, 1);
      repeat (n) issue(OP_PUSH, pick_stamp(), pick_type());
    end else if (kind < 6) begin
      // Decode order in, display order out.
      n = $urandom_range(60, 10);
      repeat (n) begin
        roll = $urandom_range(99);
        if (board.held < 3 || roll < 55) issue(OP_PUSH, pick_stamp(), pick_type());
        else if (roll < 85) issue(OP_DPOP, pick_stamp(), pick_type());
        else if (roll < 95) issue(OP_POP, pick_stamp(), pick_type());
        else issue(OP_PEEK, pick_stamp(), pick_type());
      end
    end else if (kind < 8) begin
      // Drain to empty, then poke the empty queue.
      while (board.held != 0) begin
        roll = $urandom_range(9);
        op = (roll < 6) ? OP_DPOP : (roll < 9) ? OP_POP : OP_PEEK;
        issue(op, pick_stamp(), pick_type());
      end
      repeat (2) begin
        roll = $urandom_range(2);
        op = (roll == 0) ? OP_DPOP : (roll == 1) ? OP_POP : OP_PEEK;
        issue(op, pick_stamp(), pick_type());
      end
    end else begin
      // Noise: any opcode, spare ones and the occasional flush included.
      n = $urandom_range(20, 5);
      repeat (n) begin
        op = OP_W'($urandom_range(OP_SPARE_HI));
        issue(op, pick_stamp(), TYPE_W'($urandom_range(7)));
      end
    end
  endtask

  // Result side: check every transaction taken, stall at random.
  initial begin : result_sink
    queue_result_t got;
    int unsigned   stall_left;
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got.stamp         = rsp_if.stamp_out;
        got.typ           = rsp_if.type_out;
        got.entry_valid   = rsp_if.entry_valid;
        got.push_accepted = rsp_if.push_accepted;
        got.fill          = rsp_if.fill_count;
        board.check_result(got);
      end
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = ($urandom_range(2) == 0) ? pick_gap() : 0;
        if (stall_left > 0) begin
          rsp_if.ready <= 1'b0;
          stall_left--;
        end else begin
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
  initial begin : receiver_hold
    wait (pressure_req);
    hold_off <= 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog: end the run if it drags on far past any correct run.
  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned next_phase;
    int unsigned phase;
    cmd_if.valid     = 1'b0;
    cmd_if.operation = OP_PUSH;
    cmd_if.stamp_in  = '0;
    cmd_if.type_in   = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_BIDIR;
    cfg_if.data      = '0;
    rst_ni           = 1'b0;
    sent             = 0;
    settings         = 0;
    phase            = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty queue: every read flavor and two of the spare opcodes return nothing.
    calm = 1'b1;
    issue(OP_POP, '0, '0);
    issue(OP_PEEK, '0, '0);
    issue(OP_DPOP, '0, '0);
    issue(OP_SPARE_LO, STAMP_MAX, 3'd7);
    issue(OP_SPARE_HI, STAMP_MIN, 3'd7);

    // Extreme stamps, non-bidirectional head with a non-bidirectional second.
    issue(OP_PUSH, STAMP_MIN, 3'd0);
    issue(OP_PUSH, STAMP_MAX, 3'd7);
    issue(OP_PUSH, '0, BIDIR_RESET);
    issue(OP_PUSH, -1, BIDIR_RESET);
    issue(OP_SPARE_MID, '0, '0);
    issue(OP_PEEK, '0, '0);
    issue(OP_DPOP, '0, '0);    // head taken, second not bidirectional
    issue(OP_DPOP, '0, '0);    // bidirectional second taken, head slides back
    issue(OP_DPOP, '0, '0);    // again, with the moved head in front
    issue(OP_DPOP, '0, '0);    // single entry left: head returned

    // Bidirectional head: no reorder even with a bidirectional second.
    issue(OP_PUSH, 5, BIDIR_RESET);
    issue(OP_PUSH, 6, BIDIR_RESET);
    issue(OP_DPOP, '0, '0);
    issue(OP_FLUSH, STAMP_MAX, 3'd7);
    issue(OP_POP, '0, '0);
    issue(OP_PUSH, 32'h5555_5555, 3'd5);
    issue(OP_PUSH, 32'haaaa_aaaa, 3'd2);
    issue(OP_POP, '0, '0);
    issue(OP_FLUSH, '0, '0);

    // Top codes for both registers; spare indexes must be dropped.
    apply_setting(3'd7, 3'd7);
    load_register(CFG_SPARE_LO, 3'd0);
    load_register(CFG_SPARE_HI, 3'd5);
    issue(OP_POP, '0, '0);

    // Hold off the receiver while pushes keep coming: the block must back up.
    calm         = 1'b1;
    pressure_req = 1'b1;
    repeat (40) issue(OP_PUSH, pick_stamp(), pick_type());
    calm = 1'b0;

    next_phase = sent + PHASE_ITEMS;
    while (sent < RANDOM_ITEMS + 25) begin
      run_episode();
      if (sent >= next_phase) begin
        case (phase % 4)
          0: apply_setting(3'd0, 3'd7);
          1: apply_setting(TYPE_W'($urandom_range(7)), TYPE_W'($urandom_range(7)));
          2: apply_setting(3'd7, 3'd0);
          default: apply_setting(BIDIR_RESET, INVALID_RESET);
        endcase
        phase++;
        next_phase = sent + PHASE_ITEMS;
      end
    end

    // Let the last results drain, then watch a little longer for strays.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands, checked %0d results: %0d reordered pops, %0d refused pushes",
             sent, board.checked, board.swaps, board.refused);
    $display("Applied %0d register settings, held the receiver off for %0d cycles",
             settings, PRESSURE_CYCLES);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
